FILE: design/llx_pkg.sv
// llx_pkg: shared constants and types for the line lexer
// used by the lexer top level, its checker and the bench
package llx_pkg;

  localparam int MAX_TOKEN_LEN = 31;
  localparam int TLEN_W        = $clog2(MAX_TOKEN_LEN + 1);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_LPAREN = 8'h28;

  typedef enum logic [2:0] {
    KIND_NUM  = 3'd0,
    KIND_NAME = 3'd1,
    KIND_CMP  = 3'd2,
    KIND_SYM  = 3'd3,
    KIND_EOL  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SYNTAX   = 2'd1,
    STATUS_DANGLING = 2'd2,
    STATUS_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    MODE_NONE = 4'b0001,
    MODE_NUM  = 4'b0010,
    MODE_NAME = 4'b0100,
    MODE_CMP  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [7:0] out_char;
    kind_t      kind;
    logic       token_last;
    status_t    status;
  } res_t;

endpackage

FILE: design/llx_if.sv
// llx_if: valid/ready channel interfaces for line bytes and token results
// depends on nothing but plain logic types
interface llx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface llx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [2:0] kind;
  logic       token_last;
  logic [1:0] status;

  modport source (output valid, output out_char, output kind, output token_last,
                  output status, input ready);
  modport sink   (input valid, input out_char, input kind, input token_last,
                  input status, output ready);
endinterface

FILE: design/lisp_line_lexer.sv
// lisp_line_lexer: top level of the line lexer
// depends on llx_pkg and the channel interfaces in llx_if.sv
// A line arrives one byte per transaction on in_chan, byte 0 closing it, and
// one byte is accepted in every cycle while the output queue has two free
// entries. Each byte is judged with the next one as lookahead, so a token
// character leaves one byte after it came in; each accepted byte yields zero,
// one or two result transactions (a token character, then the end-of-line
// result), written in the same cycle into a four-entry output queue that
// drains one transaction per cycle on out_chan while ready is high. The queue
// sets the sustained rate: one byte per cycle on average as long as the line
// does not produce more results than bytes. Every line ends with exactly one
// end-of-line or abort result; after an abort the rest of the line is dropped.
module lisp_line_lexer (
  input  logic       clk,
  input  logic       rst_n,
  llx_in_if.sink     in_chan,
  llx_out_if.source  out_chan
);

  logic [7:0]                  held_char_r, held_char_nxt;
  logic                        held_valid_r, held_valid_nxt;
  logic [7:0]                  cbh_r, cbh_nxt;
  logic                        at_line_start_r, at_line_start_nxt;
  llx_pkg::mode_t              mode_r, mode_nxt;
  logic [llx_pkg::TLEN_W-1:0]  tlen_r, tlen_nxt;
  logic                        aborted_r, aborted_nxt;
  logic                        warn_r, warn_nxt;

  llx_pkg::res_t               oq_r [llx_pkg::OQ_DEPTH];
  logic [llx_pkg::OQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [llx_pkg::OQ_CW-1:0]   cnt_r;

  logic                        in_acc, out_acc;
  logic [7:0]                  c, h;
  logic                        c_digit, c_alpha, h_digit, h_alpha;
  logic                        lex_v, eol_v, abort_v, run_sel, run_more;
  llx_pkg::kind_t              run_kind;
  llx_pkg::status_t            abort_st;
  llx_pkg::res_t               lex_res, eol_res, first_res;
  logic [llx_pkg::OQ_CW-1:0]   n_push;

  function automatic logic is_digit(input logic [7:0] x);
    return (x >= 8'h30) && (x <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] x);
    return ((x >= 8'h61) && (x <= 8'h7a)) || ((x >= 8'h41) && (x <= 8'h5a));
  endfunction

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;
  assign c       = in_chan.ch;
  assign h       = held_char_r;
  assign c_digit = is_digit(c);
  assign c_alpha = is_alpha(c);
  assign h_digit = is_digit(h);
  assign h_alpha = is_alpha(h);

  assign in_chan.ready = (cnt_r <= llx_pkg::OQ_CW'(llx_pkg::OQ_DEPTH - 2));

  always_comb begin
    held_char_nxt     = held_char_r;
    held_valid_nxt    = held_valid_r;
    cbh_nxt           = cbh_r;
    at_line_start_nxt = at_line_start_r;
    mode_nxt          = mode_r;
    tlen_nxt          = tlen_r;
    aborted_nxt       = aborted_r;
    warn_nxt          = warn_r;
    lex_v             = 1'b0;
    eol_v             = 1'b0;
    abort_v           = 1'b0;
    abort_st          = llx_pkg::STATUS_OK;
    run_sel           = 1'b0;
    run_more          = 1'b0;
    run_kind          = llx_pkg::KIND_NUM;
    lex_res           = '{out_char: h, kind: llx_pkg::KIND_SYM, token_last: 1'b1,
                          status: llx_pkg::STATUS_OK};
    eol_res           = '{out_char: llx_pkg::CH_NUL, kind: llx_pkg::KIND_EOL,
                          token_last: 1'b1, status: llx_pkg::STATUS_OK};

    if (in_acc) begin
      if (aborted_r) begin
        if (c == llx_pkg::CH_NUL) begin
          held_char_nxt     = llx_pkg::CH_NUL;
          held_valid_nxt    = 1'b0;
          cbh_nxt           = llx_pkg::CH_NUL;
          at_line_start_nxt = 1'b1;
          mode_nxt          = llx_pkg::MODE_NONE;
          tlen_nxt          = '0;
          aborted_nxt       = 1'b0;
          warn_nxt          = 1'b0;
        end
      end else begin
        if (held_valid_r) begin
          case (mode_r)
            llx_pkg::MODE_NUM: begin
              run_sel  = 1'b1;
              run_kind = llx_pkg::KIND_NUM;
              run_more = c_digit;
            end
            llx_pkg::MODE_NAME: begin
              run_sel  = 1'b1;
              run_kind = llx_pkg::KIND_NAME;
              run_more = c_alpha;
            end
            llx_pkg::MODE_CMP: begin
              mode_nxt     = llx_pkg::MODE_NONE;
              lex_v        = 1'b1;
              lex_res.kind = llx_pkg::KIND_CMP;
            end
            default: begin
              if (h == llx_pkg::CH_SPACE) begin
                lex_v = 1'b0;
              end else if (h_digit) begin
                run_sel  = 1'b1;
                run_kind = llx_pkg::KIND_NUM;
                run_more = c_digit;
              end else if (h_alpha) begin
                run_sel  = 1'b1;
                run_kind = llx_pkg::KIND_NAME;
                run_more = c_alpha;
              end else if (h == llx_pkg::CH_MINUS) begin
                if (c_digit) begin
                  if (at_line_start_r || (cbh_r == llx_pkg::CH_LPAREN)) begin
                    abort_v  = 1'b1;
                    abort_st = llx_pkg::STATUS_SYNTAX;
                  end else begin
                    run_sel  = 1'b1;
                    run_kind = llx_pkg::KIND_NUM;
                    run_more = 1'b1;
                  end
                end else begin
                  lex_v = 1'b1;
                end
              end else if ((h == llx_pkg::CH_LT) || (h == llx_pkg::CH_GT)) begin
                if (c == llx_pkg::CH_NUL) begin
                  warn_nxt = 1'b1;
                end else if (c == llx_pkg::CH_EQ) begin
                  mode_nxt           = llx_pkg::MODE_CMP;
                  lex_v              = 1'b1;
                  lex_res.kind       = llx_pkg::KIND_CMP;
                  lex_res.token_last = 1'b0;
                end else begin
                  lex_v        = 1'b1;
                  lex_res.kind = llx_pkg::KIND_CMP;
                end
              end else begin
                lex_v = 1'b1;
              end
            end
          endcase

          if (run_sel) begin
            if (tlen_r >= llx_pkg::TLEN_W'(llx_pkg::MAX_TOKEN_LEN)) begin
              abort_v  = 1'b1;
              abort_st = llx_pkg::STATUS_TOO_LONG;
            end else begin
              lex_v              = 1'b1;
              lex_res.kind       = run_kind;
              lex_res.token_last = !run_more;
              if (run_more) begin
                tlen_nxt = tlen_r + llx_pkg::TLEN_W'(1);
                mode_nxt = (run_kind == llx_pkg::KIND_NUM) ? llx_pkg::MODE_NUM
                                                           : llx_pkg::MODE_NAME;
              end else begin
                tlen_nxt = '0;
                mode_nxt = llx_pkg::MODE_NONE;
              end
            end
          end

          if (abort_v) begin
            lex_v          = 1'b1;
            lex_res        = '{out_char: llx_pkg::CH_NUL, kind: llx_pkg::KIND_EOL,
                               token_last: 1'b1, status: abort_st};
            aborted_nxt    = 1'b1;
            held_valid_nxt = 1'b0;
            mode_nxt       = llx_pkg::MODE_NONE;
            tlen_nxt       = '0;
          end
        end

        if (!abort_v && (c != llx_pkg::CH_NUL)) begin
          if (held_valid_r) begin
            cbh_nxt           = held_char_r;
            at_line_start_nxt = 1'b0;
          end
          held_char_nxt  = c;
          held_valid_nxt = 1'b1;
        end else if (c == llx_pkg::CH_NUL) begin
          if (!abort_v) begin
            eol_v          = 1'b1;
            eol_res.status = warn_nxt ? llx_pkg::STATUS_DANGLING : llx_pkg::STATUS_OK;
          end
          held_char_nxt     = llx_pkg::CH_NUL;
          held_valid_nxt    = 1'b0;
          cbh_nxt           = llx_pkg::CH_NUL;
          at_line_start_nxt = 1'b1;
          mode_nxt          = llx_pkg::MODE_NONE;
          tlen_nxt          = '0;
          aborted_nxt       = 1'b0;
          warn_nxt          = 1'b0;
        end
      end
    end
  end

  assign n_push    = llx_pkg::OQ_CW'(lex_v) + llx_pkg::OQ_CW'(eol_v);
  assign first_res = lex_v ? lex_res : eol_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r     <= llx_pkg::CH_NUL;
      held_valid_r    <= 1'b0;
      cbh_r           <= llx_pkg::CH_NUL;
      at_line_start_r <= 1'b1;
      mode_r          <= llx_pkg::MODE_NONE;
      tlen_r          <= '0;
      aborted_r       <= 1'b0;
      warn_r          <= 1'b0;
      wr_ptr_r        <= '0;
      rd_ptr_r        <= '0;
      cnt_r           <= '0;
    end else begin
      held_char_r     <= held_char_nxt;
      held_valid_r    <= held_valid_nxt;
      cbh_r           <= cbh_nxt;
      at_line_start_r <= at_line_start_nxt;
      mode_r          <= mode_nxt;
      tlen_r          <= tlen_nxt;
      aborted_r       <= aborted_nxt;
      warn_r          <= warn_nxt;
      wr_ptr_r        <= wr_ptr_r + llx_pkg::OQ_AW'(n_push);
      rd_ptr_r        <= rd_ptr_r + llx_pkg::OQ_AW'(out_acc);
      cnt_r           <= cnt_r + n_push - llx_pkg::OQ_CW'(out_acc);
    end
  end

  // output queue payload, no reset
  always_ff @(posedge clk) begin
    if (lex_v || eol_v) begin
      oq_r[wr_ptr_r] <= first_res;
    end
    if (lex_v && eol_v) begin
      oq_r[wr_ptr_r + llx_pkg::OQ_AW'(1)] <= eol_res;
    end
  end

  assign out_chan.valid      = (cnt_r != '0);
  assign out_chan.out_char   = oq_r[rd_ptr_r].out_char;
  assign out_chan.kind       = oq_r[rd_ptr_r].kind;
  assign out_chan.token_last = oq_r[rd_ptr_r].token_last;
  assign out_chan.status     = oq_r[rd_ptr_r].status;

endmodule

FILE: design/llx_checker.sv
// llx_checker: port-level assertions for the line lexer
// depends on llx_pkg; bound to lisp_line_lexer at the end of this file
module llx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic [2:0] kind,
  input logic       token_last,
  input logic [1:0] status
);

  // a stalled transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(kind)
      && $stable(token_last) && $stable(status))
    else $error("output transaction changed while stalled");

  // end-of-line and abort results carry no character and close their token
  a_eol_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == llx_pkg::KIND_EOL) |-> (out_char == llx_pkg::CH_NUL) && token_last)
    else $error("malformed end-of-line result");

  // only end-of-line results report a status
  a_status_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != llx_pkg::STATUS_OK) |-> (kind == llx_pkg::KIND_EOL))
    else $error("status on a token character");

  // only runs and comparisons continue past a character
  a_open_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !token_last |-> (kind == llx_pkg::KIND_NUM) ||
      (kind == llx_pkg::KIND_NAME) || (kind == llx_pkg::KIND_CMP))
    else $error("open token of a single-character kind");

endmodule

bind lisp_line_lexer llx_checker u_llx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_char   (out_chan.out_char),
  .kind       (out_chan.kind),
  .token_last (out_chan.token_last),
  .status     (out_chan.status)
);

FILE: bench/llx_token_checker.sv
`timescale 1ns / 1ps
// llx_token_checker: watches both lexer channels, predicts the token stream from
// the accepted line bytes and compares every result transaction field by field
// depends on llx_pkg and the channel interfaces in llx_if.sv
module llx_token_checker
  import llx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  llx_in_if    in_mon,
  llx_out_if   out_mon,
  output int   errors,
  output int   tokens_awaited,
  output int   tokens_seen,
  output int   bytes_lexed,
  output int   aborted_lines,
  output int   dangling_lines
);

  logic [7:0] held_ch;
  logic [7:0] prior_ch;
  logic       held_ok;
  logic       line_start;
  logic       line_dead;
  logic       warn;
  mode_t      mode;
  logic [7:0] tok_len;
  res_t       awaited_tokens[$];

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  task automatic emit(input logic [7:0] c, input kind_t k, input logic last,
                      input status_t s);
    awaited_tokens.push_back('{c, k, last, s});
  endtask

  task automatic restart_line();
    held_ch    = CH_NUL;
    held_ok    = 1'b0;
    prior_ch   = CH_NUL;
    line_start = 1'b1;
    mode       = MODE_NONE;
    tok_len    = '0;
    line_dead  = 1'b0;
    warn       = 1'b0;
  endtask

  task automatic abort_line(input status_t s);
    emit(CH_NUL, KIND_EOL, 1'b1, s);
    line_dead = 1'b1;
    held_ok   = 1'b0;
    mode      = MODE_NONE;
    tok_len   = '0;
    aborted_lines++;
  endtask

  task automatic run_char(input logic [7:0] h, input kind_t k, input logic more);
    if (tok_len >= MAX_TOKEN_LEN) begin
      abort_line(STATUS_TOO_LONG);
    end else begin
      emit(h, k, !more, STATUS_OK);
      if (more) begin
        tok_len = tok_len + 8'd1;
        mode    = (k == KIND_NUM) ? MODE_NUM : MODE_NAME;
      end else begin
        tok_len = '0;
        mode    = MODE_NONE;
      end
    end
  endtask

  // held byte judged against the byte just accepted
  task automatic judge_held(input logic [7:0] c);
    logic [7:0] h;
    h = held_ch;
    if (mode == MODE_NUM) begin
      run_char(h, KIND_NUM, is_digit(c));
    end else if (mode == MODE_NAME) begin
      run_char(h, KIND_NAME, is_letter(c));
    end else if (mode == MODE_CMP) begin
      mode = MODE_NONE;
      emit(h, KIND_CMP, 1'b1, STATUS_OK);
    end else if (h == CH_SPACE) begin
    end else if (is_digit(h)) begin
      run_char(h, KIND_NUM, is_digit(c));
    end else if (is_letter(h)) begin
      run_char(h, KIND_NAME, is_letter(c));
    end else if (h == CH_MINUS) begin
      if (!is_digit(c)) begin
        emit(h, KIND_SYM, 1'b1, STATUS_OK);
      end else if (line_start || prior_ch == CH_LPAREN) begin
        abort_line(STATUS_SYNTAX);
      end else begin
        run_char(h, KIND_NUM, 1'b1);
      end
    end else if (h == CH_LT || h == CH_GT) begin
      if (c == CH_NUL) begin
        warn = 1'b1;
      end else if (c == CH_EQ) begin
        mode = MODE_CMP;
        emit(h, KIND_CMP, 1'b0, STATUS_OK);
      end else begin
        emit(h, KIND_CMP, 1'b1, STATUS_OK);
      end
    end else begin
      emit(h, KIND_SYM, 1'b1, STATUS_OK);
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    if (line_dead) begin
      if (c == CH_NUL) restart_line();
    end else begin
      bytes_lexed++;
      if (held_ok) judge_held(c);
      if (line_dead) begin
        if (c == CH_NUL) restart_line();
      end else if (c == CH_NUL) begin
        emit(CH_NUL, KIND_EOL, 1'b1, warn ? STATUS_DANGLING : STATUS_OK);
        if (warn) dangling_lines++;
        restart_line();
      end else begin
        if (held_ok) begin
          prior_ch   = held_ch;
          line_start = 1'b0;
        end
        held_ch = c;
        held_ok = 1'b1;
      end
    end
  endtask

  task automatic check_token();
    res_t exp;
    if (awaited_tokens.size() == 0) begin
      $error("result with no token awaited: out_char %02h kind %0d", out_mon.out_char,
             out_mon.kind);
      errors++;
    end else begin
      exp = awaited_tokens.pop_front();
      tokens_seen++;
      if (out_mon.out_char !== exp.out_char) begin
        $error("out_char expected %02h actual %02h", exp.out_char, out_mon.out_char);
        errors++;
      end
      if (out_mon.kind !== exp.kind) begin
        $error("kind expected %0d actual %0d", exp.kind, out_mon.kind);
        errors++;
      end
      if (out_mon.token_last !== exp.token_last) begin
        $error("token_last expected %0b actual %0b", exp.token_last, out_mon.token_last);
        errors++;
      end
      if (out_mon.status !== exp.status) begin
        $error("status expected %0d actual %0d", exp.status, out_mon.status);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_line();
      awaited_tokens.delete();
      errors         = 0;
      tokens_seen    = 0;
      bytes_lexed    = 0;
      aborted_lines  = 0;
      dangling_lines = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) lex_byte(in_mon.ch);
      if (out_mon.valid && out_mon.ready) check_token();
    end
    tokens_awaited <= awaited_tokens.size();
  end

endmodule

FILE: bench/tb_lisp_line_lexer.sv
`timescale 1ns / 1ps
// tb_lisp_line_lexer: drives line bytes into the lexer with random idling on both
// channels and gives the verdict; depends on llx_pkg, llx_if.sv and llx_token_checker
module tb_lisp_line_lexer;
  import llx_pkg::*;

  localparam int ITEMS       = 1600;
  localparam int QUIET_TAIL  = 250;
  localparam int STALL_LIMIT = 4000;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] SYMBOLS [8] = '{CH_RPAREN, 8'h2b, 8'h2a, CH_EQ, CH_MINUS,
                                         8'h27, 8'h23, 8'h2f};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  llx_in_if  in_chan();
  llx_out_if out_chan();

  int errors, tokens_awaited, tokens_seen, bytes_lexed, aborted_lines, dangling_lines;
  int bytes_sent, lines_sent, gap_pct, stall_pct, idle_cycles, stall_left;
  int phase, last_phase;
  logic [7:0] line_q[$];

  lisp_line_lexer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  llx_token_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .errors         (errors),
    .tokens_awaited (tokens_awaited),
    .tokens_seen    (tokens_seen),
    .bytes_lexed    (bytes_lexed),
    .aborted_lines  (aborted_lines),
    .dangling_lines (dangling_lines)
  );

  // receiver: drops ready in bursts of random length
  initial begin
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0 && stall_pct != 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_chan.ready <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        stall_left = 0;
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] c);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.ch    <= c;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
    if (c == CH_NUL) lines_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (tokens_awaited != 0) @(posedge clk);
  endtask

  // mostly short runs, now and then one just under, at or just over the length limit
  function automatic int run_len(input int lead);
    if ($urandom_range(0, 11) == 0) return MAX_TOKEN_LEN - lead + $urandom_range(0, 2) - 1;
    return $urandom_range(1, 5);
  endfunction

  task automatic add_token();
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        n = run_len(0);
        repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      2: begin
        n = run_len(1);
        line_q.push_back(CH_MINUS);
        repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      3, 4: begin
        n = run_len(0);
        repeat (n)
          line_q.push_back(($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A)
                           + 8'($urandom_range(0, 25)));
      end
      5: begin
        line_q.push_back($urandom_range(0, 1) ? CH_LT : CH_GT);
        if ($urandom_range(0, 1) == 1) line_q.push_back(CH_EQ);
      end
      6: line_q.push_back(CH_LPAREN);
      7: line_q.push_back(SYMBOLS[$urandom_range(0, 7)]);
      8: line_q.push_back(8'($urandom_range(1, 255)));
      default: line_q.push_back(CH_SPACE);
    endcase
    if ($urandom_range(0, 2) == 0) line_q.push_back(CH_SPACE);
  endtask

  task automatic build_line();
    int n;
    line_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(0, 10);
      repeat (n) line_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      n = $urandom_range(0, 8);
      repeat (n) add_token();
      if ($urandom_range(0, 7) == 0) line_q.push_back($urandom_range(0, 1) ? CH_LT : CH_GT);
    end
    line_q.push_back(CH_NUL);
  endtask

  initial begin
    in_chan.valid <= 1'b0;
    in_chan.ch    <= CH_NUL;
    bytes_sent = 0;
    lines_sent = 0;
    gap_pct    = 20;
    stall_pct  = 20;
    last_phase = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty line, negative number at start and after a paren, dangling comparison,
    // comparison with equals, lone minus and bytes at the ends of the range
    line_q = {CH_NUL,
              CH_MINUS, 8'h35, CH_NUL,
              CH_LPAREN, CH_MINUS, 8'h37, CH_RPAREN, CH_NUL,
              8'h78, CH_GT, CH_EQ, CH_MINUS, 8'h39, CH_SPACE, 8'h62, CH_GT, CH_NUL,
              CH_LT, 8'h5a, 8'hff, 8'h80, 8'h01, CH_MINUS, CH_NUL};
    send_line();
    drain();

    while (bytes_lexed < ITEMS) begin
      phase = bytes_lexed / 200;
      if (bytes_lexed >= ITEMS - QUIET_TAIL) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case (phase % 4)
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 10; stall_pct = 30; end
          2: begin gap_pct = 40; stall_pct = 10; end
          default: begin gap_pct = 25; stall_pct = 25; end
        endcase
      end
      if (phase != last_phase && phase % 2 == 0) drain();
      last_phase = phase;
      build_line();
      send_line();
    end
    drain();
    repeat (16) @(posedge clk);

    $display("%0d bytes sent over %0d lines, %0d lexed, idling on both sides then none",
             bytes_sent, lines_sent, bytes_lexed);
    $display("%0d results checked, %0d lines aborted, %0d dangling comparisons",
             tokens_seen, aborted_lines, dangling_lines);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
